// ----- rtl/rbst_pkg.sv -----
// shared types and constants for the ray / box slab test
// no dependencies
package rbst_pkg;

  localparam int WID       = 32;           // q16.16 coordinate width
  localparam int DIFF_W    = WID + 1;      // bound minus origin, exact
  localparam int FRAC_W    = 16;
  localparam int LIM_W     = 31;
  localparam int NUM_AXES  = 3;
  localparam int DIV_STEPS = WID;          // one quotient bit per stage
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int LANE_LAT  = DIV_LAT + 1;
  localparam int MERGE_LAT = 2;
  localparam int TOT_LAT   = LANE_LAT + MERGE_LAT;
  localparam int IN_W      = 224;
  localparam int OUT_W     = 8;
  localparam int IDX_W     = 3;

  localparam logic signed [WID-1:0] T_MIN = {1'b1, {(WID-1){1'b0}}};
  localparam logic signed [WID-1:0] T_MAX = {1'b0, {(WID-1){1'b1}}};

  typedef enum logic [IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [WID-1:0] near;
    logic signed [WID-1:0] far;
    logic                  miss;
  } lane_res_t;

endpackage

// ----- rtl/rbst_div.sv -----
// pipelined fixed point divider: (diff << 16) / dir, truncated, saturated
// uses rbst_pkg
module rbst_div import rbst_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DIFF_W-1:0] diff,
  input  logic signed [WID-1:0]    dir,
  output logic signed [WID-1:0]    quot
);

  logic [DIFF_W-1:0] diff_abs;
  logic [WID-1:0]    nmag;
  logic [WID-1:0]    dmag;

  logic [WID:0]   rem_r  [0:DIV_STEPS];
  logic [WID-1:0] q_r    [0:DIV_STEPS];
  logic [WID-1:0] lw_r   [0:DIV_STEPS];
  logic [WID-1:0] dmag_r [0:DIV_STEPS];
  logic           neg_r  [0:DIV_STEPS];
  logic           ovf_r  [0:DIV_STEPS];
  logic signed [WID-1:0] quot_r;
  logic signed [WID-1:0] quot_nxt;

  assign diff_abs = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
  assign nmag     = diff_abs[WID-1:0];
  assign dmag     = dir[WID-1] ? (~dir + 1'b1) : dir;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0]  <= diff[DIFF_W-1] ^ dir[WID-1];
      dmag_r[0] <= dmag;
      // quotient of 2^32 or more always saturates
      ovf_r[0]  <= {{(WID-FRAC_W){1'b0}}, nmag[WID-1:FRAC_W]} >= dmag;
      rem_r[0]  <= {{(WID-FRAC_W+1){1'b0}}, nmag[WID-1:FRAC_W]};
      lw_r[0]   <= {nmag[FRAC_W-1:0], {(WID-FRAC_W){1'b0}}};
      q_r[0]    <= '0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [WID:0] shifted;
    logic         ge;
    assign shifted = {rem_r[k][WID-1:0], lw_r[k][WID-1-k]};
    assign ge      = shifted >= {1'b0, dmag_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? (shifted - {1'b0, dmag_r[k]}) : shifted;
        q_r[k+1]    <= {q_r[k][WID-2:0], ge};
        lw_r[k+1]   <= lw_r[k];
        dmag_r[k+1] <= dmag_r[k];
        neg_r[k+1]  <= neg_r[k];
        ovf_r[k+1]  <= ovf_r[k];
      end
    end
  end

  always_comb begin
    if (neg_r[DIV_STEPS]) begin
      if (ovf_r[DIV_STEPS] || (q_r[DIV_STEPS][WID-1] && |q_r[DIV_STEPS][WID-2:0]))
        quot_nxt = T_MIN;
      else
        quot_nxt = ~q_r[DIV_STEPS] + 1'b1;
    end else begin
      if (ovf_r[DIV_STEPS] || q_r[DIV_STEPS][WID-1])
        quot_nxt = T_MAX;
      else
        quot_nxt = q_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot_r <= quot_nxt;
    end
  end

  assign quot = quot_r;

endmodule

// ----- rtl/rbst_lane.sv -----
// one axis lane: two slab distances, ordering and the zero direction check
// uses rbst_pkg and rbst_div
module rbst_lane import rbst_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [WID-1:0] org,
  input  logic signed [WID-1:0] dir,
  input  logic signed [WID-1:0] bmin,
  input  logic signed [WID-1:0] bmax,
  output lane_res_t             res
);

  logic signed [DIFF_W-1:0] diff0;
  logic signed [DIFF_W-1:0] diff1;
  logic signed [WID-1:0]    t0;
  logic signed [WID-1:0]    t1;
  logic                     zero_r [0:DIV_LAT-1];
  logic                     miss_r [0:DIV_LAT-1];
  lane_res_t                res_r;
  lane_res_t                res_nxt;

  assign diff0 = {bmin[WID-1], bmin} - {org[WID-1], org};
  assign diff1 = {bmax[WID-1], bmax} - {org[WID-1], org};

  rbst_div u_div0 (.clk(clk), .en(en), .diff(diff0), .dir(dir), .quot(t0));
  rbst_div u_div1 (.clk(clk), .en(en), .diff(diff1), .dir(dir), .quot(t1));

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (dir == '0);
      miss_r[0] <= (dir == '0) && ((org < bmin) || (org > bmax));
      for (int i = 1; i < DIV_LAT; i++) begin
        zero_r[i] <= zero_r[i-1];
        miss_r[i] <= miss_r[i-1];
      end
    end
  end

  always_comb begin
    res_nxt.miss = miss_r[DIV_LAT-1];
    if (zero_r[DIV_LAT-1]) begin
      // axis does not narrow the interval
      res_nxt.near = T_MIN;
      res_nxt.far  = T_MAX;
    end else if (t0 > t1) begin
      res_nxt.near = t1;
      res_nxt.far  = t0;
    end else begin
      res_nxt.near = t0;
      res_nxt.far  = t1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ----- rtl/rbst_merge.sv -----
// merges the lane results into the final interval test
// uses rbst_pkg
module rbst_merge import rbst_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  lane_res_t         lane [NUM_AXES],
  input  logic [LIM_W-1:0]  limit,
  output logic              hit
);

  logic signed [WID-1:0] lo_a;
  logic signed [WID-1:0] lo_b;
  logic signed [WID-1:0] hi_a;
  logic signed [WID-1:0] hi_b;
  logic signed [WID-1:0] lo_r;
  logic signed [WID-1:0] hi_r;
  logic                  miss_r;
  logic                  hit_r;

  // a two level compare tree for each end
  always_comb begin
    lo_a = (lane[0].near > lane[1].near) ? lane[0].near : lane[1].near;
    lo_b = (lane[2].near > 0) ? lane[2].near : '0;
    hi_a = (lane[0].far < lane[1].far) ? lane[0].far : lane[1].far;
    hi_b = (lane[2].far < $signed({1'b0, limit})) ? lane[2].far : $signed({1'b0, limit});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r   <= (lo_a > lo_b) ? lo_a : lo_b;
      hi_r   <= (hi_a < hi_b) ? hi_a : hi_b;
      miss_r <= lane[0].miss | lane[1].miss | lane[2].miss;
      hit_r  <= !miss_r && (lo_r <= hi_r);
    end
  end

  assign hit = hit_r;

endmodule

// ----- rtl/ray_box_slab_test_top.sv -----
// ray against axis-aligned box slab test, top level
// uses rbst_pkg, rbst_lane and rbst_merge
//
//  channel   dir  payload                                     handshake
//  in_       in   origin x/y/z, dir x/y/z, ray_limit          tvalid/tready
//  out_      out  hit                                         tvalid/tready
//  cfg_      in   box corner register index and value         we only
//
// one ray a cycle while the output is not stalled; each ray runs through the
// 32-stage restoring divider in each axis lane plus entry, order and merge registers.
// reset empties the pipeline and clears the box registers to zero.
// a stalled output holds the whole pipeline; in_tready drops only then.
module ray_box_slab_test_top import rbst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, ray_limit, zero pad
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // hit, zero pad
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  logic [WID-1:0]   cfg_wdata
);

  logic signed [WID-1:0] bmin_r [NUM_AXES];
  logic signed [WID-1:0] bmax_r [NUM_AXES];
  logic [TOT_LAT-1:0]    vld_r;
  logic [LIM_W-1:0]      lim_r [0:LANE_LAT-1];
  logic                  adv;
  lane_res_t             lane_res [NUM_AXES];
  logic                  hit;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        bmin_r[i] <= '0;
        bmax_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_MIN_X: bmin_r[0] <= cfg_wdata;
        REG_MIN_Y: bmin_r[1] <= cfg_wdata;
        REG_MIN_Z: bmin_r[2] <= cfg_wdata;
        REG_MAX_X: bmax_r[0] <= cfg_wdata;
        REG_MAX_Y: bmax_r[1] <= cfg_wdata;
        REG_MAX_Z: bmax_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[TOT_LAT-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lim_r[0] <= in_tdata[6*WID +: LIM_W];
      for (int i = 1; i < LANE_LAT; i++) begin
        lim_r[i] <= lim_r[i-1];
      end
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    rbst_lane u_lane (
      .clk  (clk),
      .en   (adv),
      .org  (in_tdata[a*WID +: WID]),
      .dir  (in_tdata[(NUM_AXES+a)*WID +: WID]),
      .bmin (bmin_r[a]),
      .bmax (bmax_r[a]),
      .res  (lane_res[a])
    );
  end

  rbst_merge u_merge (
    .clk   (clk),
    .en    (adv),
    .lane  (lane_res),
    .limit (lim_r[LANE_LAT-1]),
    .hit   (hit)
  );

  assign out_tvalid = vld_r[TOT_LAT-1];
  assign out_tdata  = {{(OUT_W-1){1'b0}}, hit};

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output state");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("pipeline not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_tvalid |=> vld_r[0])
    else $error("accepted request lost at pipeline entry");

endmodule

// ----- verif/tb_ray_box_slab_test_top.sv -----
// testbench for ray_box_slab_test_top: rays against configurable boxes
// checks every hit flag against a built-in slab-test predictor; needs rbst_pkg
module tb_ray_box_slab_test_top import rbst_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [WID-1:0] org[NUM_AXES];
    logic signed [WID-1:0] dir[NUM_AXES];
    logic [LIM_W-1:0]      limit;
  } ray_t;

  localparam int ONE = 1 << FRAC_W;
  localparam int STALL_LIMIT = 5000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_idx = '0;
  logic [WID-1:0]   cfg_wdata = '0;

  ray_t rays_pending[$];
  logic hits_expected[$];
  logic signed [WID-1:0] box_lo[NUM_AXES];
  logic signed [WID-1:0] box_hi[NUM_AXES];
  cfg_reg_t min_regs[NUM_AXES] = '{REG_MIN_X, REG_MIN_Y, REG_MIN_Z};
  cfg_reg_t max_regs[NUM_AXES] = '{REG_MAX_X, REG_MAX_Y, REG_MAX_Z};
  int errors = 0;
  int rays_sent = 0;
  int hits_seen = 0;
  int results_seen = 0;
  int cycle = 0;
  int stall_cycles = 0;

  ray_box_slab_test_top i_dut (.*);

  always #5 clk = ~clk;

  function automatic longint slab_dist(longint bound, longint org, longint dir);
    longint q;
    q = ((bound - org) * ONE) / dir;
    if (q > longint'(T_MAX)) q = T_MAX;
    if (q < longint'(T_MIN)) q = T_MIN;
    return q;
  endfunction

  function automatic logic predict_hit(ray_t r);
    longint lo, hi, t0, t1, tmp;
    logic h;
    lo = 0;
    hi = r.limit;
    h = 1'b1;
    for (int a = 0; a < NUM_AXES && h; a++) begin
      if (r.dir[a] == 0) begin
        if (r.org[a] < box_lo[a] || r.org[a] > box_hi[a]) h = 1'b0;
      end else begin
        t0 = slab_dist(box_lo[a], r.org[a], r.dir[a]);
        t1 = slab_dist(box_hi[a], r.org[a], r.dir[a]);
        if (t0 > t1) begin
          tmp = t0; t0 = t1; t1 = tmp;
        end
        if (t0 > lo) lo = t0;
        if (t1 < hi) hi = t1;
        if (lo > hi) h = 1'b0;
      end
    end
    return h;
  endfunction

  function automatic logic [IN_W-1:0] pack_ray(ray_t r);
    return {1'b0, r.limit, r.dir[2], r.dir[1], r.dir[0], r.org[2], r.org[1], r.org[0]};
  endfunction

  // long busy stretch with no idling on either side, random idling elsewhere
  function automatic bit busy();
    return (cycle > 800 && cycle < 1400) || ($urandom_range(99) >= 20);
  endfunction

  // driver
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= busy();
      if (in_tvalid && in_tready) begin
        hits_expected.push_back(predict_hit(rays_pending.pop_front()));
        rays_sent++;
      end
      if (in_tvalid && !in_tready) begin
        in_tvalid <= 1'b1;
      end else if (rays_pending.size() > 0 && busy()) begin
        in_tvalid <= 1'b1;
        in_tdata <= pack_ray(rays_pending[0]);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (hits_expected.size() == 0) begin
          $error("unexpected result: hit=%0d", out_tdata[0]);
          errors++;
        end else begin
          logic exp_hit;
          exp_hit = hits_expected.pop_front();
          if (exp_hit) hits_seen++;
          if (out_tdata[0] !== exp_hit) begin
            $error("hit mismatch: expected %0d, got %0d", exp_hit, out_tdata[0]);
            errors++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (rays_pending.size() == 0 && hits_expected.size() == 0))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic signed [WID-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_box(int x0, int y0, int z0, int x1, int y1, int z1);
    int lo[NUM_AXES];
    int hi[NUM_AXES];
    lo = '{x0, y0, z0};
    hi = '{x1, y1, z1};
    for (int a = 0; a < NUM_AXES; a++) begin
      write_reg(min_regs[a], lo[a]);
      write_reg(max_regs[a], hi[a]);
      box_lo[a] = lo[a];
      box_hi[a] = hi[a];
    end
  endtask

  task automatic drain();
    while (rays_pending.size() > 0 || hits_expected.size() > 0) @(posedge clk);
    repeat (TOT_LAT + 4) @(posedge clk);
  endtask

  task automatic add_ray(int ox, int oy, int oz, int dx, int dy, int dz, int lim);
    ray_t r;
    r.org = '{ox, oy, oz};
    r.dir = '{dx, dy, dz};
    r.limit = lim[LIM_W-1:0];
    rays_pending.push_back(r);
  endtask

  // mostly rays aimed near the box, some fully random noise
  task automatic add_random_rays(int n);
    ray_t r;
    longint tgt, span;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          r.org[a] = $urandom;
          r.dir[a] = $urandom;
        end
        r.limit = LIM_W'($urandom);
      end else begin
        for (int a = 0; a < NUM_AXES; a++) begin
          span = longint'(box_hi[a]) - longint'(box_lo[a]);
          if (span < 0) span = -span;
          if (span > 64'h3fff_ffff) span = 64'h3fff_ffff;
          tgt = longint'(box_lo[a] < box_hi[a] ? box_lo[a] : box_hi[a]) +
                longint'($urandom_range(32'(span)));
          r.org[a] = 32'(tgt + $signed(32'($urandom_range(200 * ONE))) - 100 * ONE);
          r.dir[a] = $urandom_range(5) == 0 ? 0 :
                     32'((tgt - longint'(r.org[a])) >>> $urandom_range(6));
          if ($urandom_range(9) == 0) r.dir[a] = $urandom;
        end
        r.limit = LIM_W'($urandom_range(3) == 0 ? $urandom : $urandom_range(200 * ONE));
      end
      rays_pending.push_back(r);
    end
  endtask

  initial begin
    for (int a = 0; a < NUM_AXES; a++) begin
      box_lo[a] = 0;
      box_hi[a] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // box left at reset: a single point at the origin
    add_ray(0, 0, 0, 0, 0, 0, 0);
    add_ray(-ONE, 0, 0, ONE, 0, 0, 2 * ONE);
    add_ray(ONE, 0, 0, 0, 0, 0, 32'h7fff_ffff);
    drain();

    set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
    add_ray(-5 * ONE, 0, 0, ONE, 0, 0, 32'h7fff_ffff);   // plain hit
    add_ray(-5 * ONE, 0, 0, ONE, 0, 0, ONE);             // limit short of the box
    add_ray(-5 * ONE, 0, 0, ONE, 0, 0, 4 * ONE);         // interval ends meet
    add_ray(-5 * ONE, ONE, -ONE, ONE, 0, 0, 32'h7fff_ffff);  // origin on bounds
    add_ray(-5 * ONE, ONE + 1, 0, ONE, 0, 0, 32'h7fff_ffff); // just outside slab
    add_ray(0, 0, 0, 0, 0, 0, 0);                        // inside, zero limit
    add_ray(-5 * ONE, 0, 0, -ONE, 0, 0, 32'h7fff_ffff);  // pointing away
    add_ray(32'h8000_0000, 0, 0, 1, 0, 0, 32'h7fff_ffff);   // saturated distance
    add_ray(32'h7fff_ffff, 0, 0, -1, 0, 0, 32'h7fff_ffff);
    add_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_ray(32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0, 32'h7fff_ffff);
    add_ray(-3 * ONE, -3 * ONE, -3 * ONE, ONE, ONE, ONE, 32'h7fff_ffff); // diagonal
    add_ray(-3 * ONE, 3 * ONE, 0, ONE, ONE, 0, 32'h7fff_ffff);           // diagonal miss
    drain();

    add_random_rays(250);
    drain();
    set_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);            // inverted box
    add_random_rays(200);
    drain();
    set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_random_rays(200);
    drain();
    set_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_random_rays(150);
    drain();
    set_box(3 * ONE, 3 * ONE, 3 * ONE, 3 * ONE, 3 * ONE, 3 * ONE);  // flat point box
    add_random_rays(150);
    drain();
    for (int k = 0; k < 3; k++) begin
      int c[6];
      for (int j = 0; j < 6; j++) c[j] = $signed(32'($urandom_range(400 * ONE))) - 200 * ONE;
      set_box(c[0], c[1], c[2], c[0] + $urandom_range(50 * ONE),
              c[1] + $urandom_range(50 * ONE), c[2] + $urandom_range(50 * ONE));
      add_random_rays(150);
      drain();
    end

    $display("rays sent %0d, results checked %0d, hits %0d, over 9 box settings",
             rays_sent, results_seen, hits_seen);
    if (errors == 0 && hits_expected.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/rbst_pkg.sv
rtl/rbst_div.sv
rtl/rbst_lane.sv
rtl/rbst_merge.sv
rtl/ray_box_slab_test_top.sv
verif/tb_ray_box_slab_test_top.sv
